// File: src/mscap_pkg.sv
// ----------------------------------------------------------------------------
// mscap_pkg
// Shared widths, status codes and register indexes for the Manchester
// sync-word frame capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package mscap_pkg;

  localparam int SAMPLE_W = 16;            // ADC sample width
  localparam int SUM_W    = SAMPLE_W + 2;  // sum of four samples
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 12;            // word_index port width
  localparam int LEN_W    = 13;            // frame_length / capture index width
  localparam int PAT_W    = 24;            // sync_pattern register width
  localparam int CFG_W    = 24;            // widest register
  localparam int CFG_IDX_W = 1;
  localparam int SLOT_LEN = 8;             // samples per slot
  localparam int HALF_LEN = 4;             // early / late half of a slot

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 1'd1;

  localparam logic [PAT_W-1:0] SYNC_PATTERN_RST = 24'hF4CFB3;
  localparam logic [LEN_W-1:0] FRAME_LENGTH_RST = 13'd2048;
  localparam logic [LEN_W-1:0] LEN_MAX          = 13'h1FFF;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_SEARCH  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SYNC    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WORD    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

endpackage

`default_nettype wire

// File: src/mscap_cell.sv
// ----------------------------------------------------------------------------
// mscap_cell
// One 8-sample slot of the sliding window. Shifts one sample per beat toward
// the oldest end and reports whether the early half outweighs the late half.
// ----------------------------------------------------------------------------
`default_nettype none

module mscap_cell
  import mscap_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                shift_en,
  input  wire logic [SAMPLE_W-1:0] din_i,    // from newer neighbor
  output logic      [SAMPLE_W-1:0] dout_o,   // to older neighbor
  output logic                     bit_o
);

  logic [SAMPLE_W-1:0] smp_r [SLOT_LEN];     // index 0 oldest
  logic [SUM_W-1:0]    early_sum;
  logic [SUM_W-1:0]    late_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_LEN; i++) smp_r[i] <= '0;
    end else if (shift_en) begin
      for (int i = 0; i < SLOT_LEN - 1; i++) smp_r[i] <= smp_r[i+1];
      smp_r[SLOT_LEN-1] <= din_i;
    end
  end

  always_comb begin
    early_sum = '0;
    late_sum  = '0;
    for (int i = 0; i < HALF_LEN; i++) begin
      early_sum = early_sum + SUM_W'(smp_r[i]);
      late_sum  = late_sum + SUM_W'(smp_r[HALF_LEN+i]);
    end
  end

  assign bit_o  = (early_sum > late_sum);
  assign dout_o = smp_r[0];

endmodule

`default_nettype wire

// File: src/manchester_sync_frame_capture_top.sv
// ----------------------------------------------------------------------------
// manchester_sync_frame_capture_top
// Sync-word correlator over a sliding sample window, followed by frame capture.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one ADC sample per beat plus a rearm
//   flag. Output channel (out_valid / out_stall): exactly one result beat per
//   input beat, in order: status, word_index, word_value.
//   Config port: cfg_we with cfg_index 0 writes sync_pattern, 1 writes
//   frame_length. Write only while no beat is in flight.
// Timing:
//   A sample taken while searching shifts the cell chain and sets busy; the
//   24 slot bits are matched once busy is set and no result is held, and the
//   result is registered into the output register. No new input beat is taken
//   while busy. Rearm, capture and done beats are answered straight into the
//   output register, one per cycle while the output is not stalled.
// Reset: window cleared to zero, mode searching, registers to their defaults.
// Stall: a stalled result holds in the output register; no new input beat is
//   taken until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module manchester_sync_frame_capture_top
  import mscap_pkg::*;
#(
  parameter int WINDOW_SAMPLES = 192,   // 16..512
  parameter int FRAME_DEPTH    = 4096,  // 256..65536
  parameter int SYNC_BITS      = 24     // 8..32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  input  wire logic                 in_rearm,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [STATUS_W-1:0]  out_status,
  output logic      [INDEX_W-1:0]   out_word_index,
  output logic      [SAMPLE_W-1:0]  out_word_value,
  // config port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int NSLOTS   = WINDOW_SAMPLES / SLOT_LEN;
  localparam int TAIL_LEN = WINDOW_SAMPLES % SLOT_LEN;  // newest, no slot bit
  localparam int BIT_OFFS = SYNC_BITS - NSLOTS;          // bit of slot 0
  localparam int DEPTH_CAP = (FRAME_DEPTH > 8191) ? 8191 : FRAME_DEPTH;
  localparam logic [LEN_W-1:0] DEPTH_LIM   = LEN_W'(DEPTH_CAP);
  localparam logic [LEN_W-1:0] WINDOW_IDX  = LEN_W'(WINDOW_SAMPLES);

  // mode codes
  localparam logic [1:0] MODE_SEARCH  = 2'd0;
  localparam logic [1:0] MODE_CAPTURE = 2'd1;
  localparam logic [1:0] MODE_DONE    = 2'd2;

  // ---------------- config registers ----------------
  logic [PAT_W-1:0] sync_pattern_r;
  logic [LEN_W-1:0] frame_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pattern_r <= SYNC_PATTERN_RST;
      frame_length_r <= FRAME_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_PATTERN: sync_pattern_r <= cfg_data[PAT_W-1:0];
        CFG_FRAME_LENGTH: frame_length_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic busy_r, busy_nxt;      // shifted window awaiting its match cycle
  logic out_valid_r, out_valid_nxt;
  logic out_hold;
  logic in_acc;
  logic shift_en;
  logic eval;
  logic [1:0] mode_r, mode_nxt;

  assign out_hold = out_valid_r & out_stall;
  assign in_stall = busy_r | out_hold;
  assign in_acc   = in_valid & ~in_stall;
  assign shift_en = in_acc & ~in_rearm & (mode_r == MODE_SEARCH);
  assign eval     = busy_r & ~out_hold;

  // ---------------- window: tail + cell chain ----------------
  logic [SAMPLE_W-1:0] tail_out;
  logic [SAMPLE_W-1:0] link [NSLOTS+1];  // link[k] leaves cell k toward older
  logic [NSLOTS-1:0]   slot_bit;

  generate
    if (TAIL_LEN > 0) begin : g_tail
      logic [SAMPLE_W-1:0] tail_r [TAIL_LEN];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          for (int i = 0; i < TAIL_LEN; i++) tail_r[i] <= '0;
        end else if (shift_en) begin
          for (int i = 0; i < TAIL_LEN - 1; i++) tail_r[i] <= tail_r[i+1];
          tail_r[TAIL_LEN-1] <= in_sample;
        end
      end
      assign tail_out = tail_r[0];
    end else begin : g_no_tail
      assign tail_out = in_sample;
    end
  endgenerate

  assign link[NSLOTS] = tail_out;

  generate
    for (genvar k = 0; k < NSLOTS; k++) begin : g_cell
      mscap_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .din_i    (link[k+1]),
        .dout_o   (link[k]),
        .bit_o    (slot_bit[k])
      );
    end
  endgenerate

  // oldest sample falls off the end of the chain
  logic [SAMPLE_W-1:0] drop_sample;
  assign drop_sample = link[0];

  // slot k lands at bit BIT_OFFS+k; slots below bit 0 are shifted out
  logic [SYNC_BITS-1:0] word_bits;
  generate
    for (genvar b = 0; b < SYNC_BITS; b++) begin : g_bits
      localparam int S = b - BIT_OFFS;
      if (S >= 0 && S < NSLOTS) begin : g_on
        assign word_bits[b] = slot_bit[S];
      end else begin : g_off
        assign word_bits[b] = 1'b0;
      end
    end
  endgenerate

  logic [31:0]          pat_ext;
  logic [SYNC_BITS-1:0] pat;
  logic                 match;

  assign pat_ext = {{(32-PAT_W){1'b0}}, sync_pattern_r};
  assign pat     = pat_ext[SYNC_BITS-1:0];
  assign match   = (word_bits == pat) || (word_bits == ~pat);

  // ---------------- capture control ----------------
  logic [LEN_W-1:0] capture_idx_r, capture_idx_nxt;
  logic [LEN_W-1:0] cap_end;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [SAMPLE_W-1:0] out_value_r, out_value_nxt;
  logic                load;

  assign cap_end = (frame_length_r > DEPTH_LIM) ? DEPTH_LIM : frame_length_r;

  always_comb begin
    mode_nxt        = mode_r;
    capture_idx_nxt = capture_idx_r;
    busy_nxt        = busy_r;
    load            = 1'b0;
    out_status_nxt  = ST_SEARCH;
    out_index_nxt   = '0;
    out_value_nxt   = '0;

    if (eval) begin
      busy_nxt = 1'b0;
      load     = 1'b1;
      if (match) begin
        mode_nxt        = MODE_CAPTURE;
        capture_idx_nxt = WINDOW_IDX;
        out_status_nxt  = ST_SYNC;
      end
    end else if (in_acc) begin
      if (in_rearm) begin
        mode_nxt        = MODE_SEARCH;
        capture_idx_nxt = '0;
        load            = 1'b1;
        out_status_nxt  = ST_IGNORED;
      end else begin
        unique case (mode_r)
          MODE_SEARCH: busy_nxt = 1'b1;   // result after the match cycle
          MODE_CAPTURE: begin
            load = 1'b1;
            if (capture_idx_r < cap_end) begin
              out_status_nxt  = ST_WORD;
              out_index_nxt   = capture_idx_r[INDEX_W-1:0];
              out_value_nxt   = in_sample;
              capture_idx_nxt = capture_idx_r + 1'b1;
            end else begin
              mode_nxt       = MODE_DONE;
              out_status_nxt = ST_DONE;
            end
          end
          default: begin                 // done, and unused code
            load           = 1'b1;
            mode_nxt       = MODE_DONE;
            out_status_nxt = ST_DONE;
          end
        endcase
      end
    end

    if (load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_SEARCH;
      capture_idx_r <= '0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      capture_idx_r <= capture_idx_nxt;
      busy_r        <= busy_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload needs no reset; only loaded when the output slot is free
  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      out_value_r  <= out_value_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_word_index = out_index_r;
  assign out_word_value = out_value_r;

endmodule

`default_nettype wire

// File: src/mscap_checker.sv
// ----------------------------------------------------------------------------
// mscap_checker
// Port-level checks for the frame capture block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mscap_checker
  import mscap_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                in_rearm,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [INDEX_W-1:0]  out_word_index,
  input wire logic [SAMPLE_W-1:0] out_word_value
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_word_index) && $stable(out_word_value))
    else $error("stalled result beat changed");

  // rearm beat is answered on the next cycle with the ignored status
  a_rearm_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_rearm |=> out_valid && out_status == ST_IGNORED)
    else $error("rearm beat not answered with ignored status");

  // word fields are zero unless a word is stored
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_WORD |-> out_word_index == '0
      && out_word_value == '0)
    else $error("word fields nonzero on a non-word result");

endmodule

bind manchester_sync_frame_capture_top mscap_checker u_mscap_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_rearm       (in_rearm),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_word_index (out_word_index),
  .out_word_value (out_word_value)
);

`default_nettype wire

// File: test/tb_manchester_sync_frame_capture_top.sv
// ----------------------------------------------------------------------------
// tb_manchester_sync_frame_capture_top
// Self-checking bench for the sync-word frame capture block. A queue of ADC
// beats (preambles, Manchester-coded sync words, frame payload, rearms) is
// fed through the input channel with random gaps while the result channel is
// stalled at random. A cycle-free model of the window, the slot correlator
// and the capture counter predicts every result beat, and each returned beat
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_manchester_sync_frame_capture_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mscap_pkg::*;

  localparam int WINDOW       = 192;
  localparam int DEPTH        = 4096;
  localparam int SYNC_BITS    = 24;
  localparam int SLOTS        = WINDOW / SLOT_LEN;
  // Longest legal quiet stretch is the longest send gap stacked on the longest
  // result stall plus the drain hold-off; this leaves a wide margin.
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_BEATS = 1300;

  typedef enum logic [1:0] {MODE_SEARCH, MODE_CAPTURE, MODE_DONE} cap_mode_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                rearm;
  } adc_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  word_index;
    logic [SAMPLE_W-1:0] word_value;
  } cap_result_t;

  // every block input holds a known value from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_sample = '0;
  logic                 in_rearm  = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [INDEX_W-1:0]   out_word_index;
  logic [SAMPLE_W-1:0]  out_word_value;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_PATTERN;
  logic [CFG_W-1:0]     cfg_data  = '0;

  manchester_sync_frame_capture_top #(
    .WINDOW_SAMPLES(WINDOW),
    .FRAME_DEPTH   (DEPTH),
    .SYNC_BITS     (SYNC_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_rearm      (in_rearm),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_word_index(out_word_index),
    .out_word_value(out_word_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Capture model: its own copy of the window, mode, counter and registers.
  // Window entry 0 is the oldest sample.
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] mdl_window [WINDOW] = '{default: '0};
  cap_mode_t           mdl_mode      = MODE_SEARCH;
  logic [LEN_W-1:0]    mdl_cap_idx   = '0;
  logic [PAT_W-1:0]    mdl_pattern   = SYNC_PATTERN_RST;
  logic [LEN_W-1:0]    mdl_frame_len = FRAME_LENGTH_RST;

  adc_beat_t   sample_feed[$];   // beats waiting to be driven
  cap_result_t owed_results[$];  // predicted result beats, oldest first

  int errors, beats_fed, n_syncs, n_words, n_done, n_rearms, n_writes;
  int send_gap, send_calm, stall_left, stall_calm, quiet_cycles;
  bit hold_for_drain;

  // One bit per 8-sample slot: set when the early half outweighs the late
  // half. Each slot shifts the word right, so slot 0 ends in bit 0.
  function automatic logic [SYNC_BITS-1:0] slot_bits();
    logic [SYNC_BITS-1:0] word;
    int early, late;
    word = '0;
    for (int s = 0; s + SLOT_LEN <= WINDOW; s += SLOT_LEN) begin
      early = 0;
      late  = 0;
      for (int j = 0; j < HALF_LEN; j++) begin
        early += mdl_window[s + j];
        late  += mdl_window[s + HALF_LEN + j];
      end
      word = word >> 1;
      if (early > late) word[SYNC_BITS-1] = 1'b1;
    end
    return word;
  endfunction

  function automatic cap_result_t capture_predict(adc_beat_t b);
    cap_result_t r;
    logic [SYNC_BITS-1:0] bits, pat;
    logic [LEN_W-1:0] stop;
    r = '0;
    if (b.rearm) begin
      // rearm wins in any mode; window is left alone
      mdl_mode    = MODE_SEARCH;
      mdl_cap_idx = '0;
      r.status    = ST_IGNORED;
      n_rearms++;
    end else begin
      case (mdl_mode)
        MODE_SEARCH: begin
          for (int i = 0; i < WINDOW - 1; i++) mdl_window[i] = mdl_window[i + 1];
          mdl_window[WINDOW-1] = b.sample;
          bits = slot_bits();
          pat  = mdl_pattern[SYNC_BITS-1:0];
          if (bits == pat || bits == ~pat) begin
            mdl_mode    = MODE_CAPTURE;
            mdl_cap_idx = LEN_W'(WINDOW);
            r.status    = ST_SYNC;
            n_syncs++;
          end else begin
            r.status = ST_SEARCH;
          end
        end
        MODE_CAPTURE: begin
          stop = (mdl_frame_len > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : mdl_frame_len;
          if (mdl_cap_idx < stop) begin
            r.status     = ST_WORD;
            r.word_index = mdl_cap_idx[INDEX_W-1:0];
            r.word_value = b.sample;
            mdl_cap_idx  = mdl_cap_idx + 1'b1;
            n_words++;
          end else begin
            // the beat that hits the end is dropped
            mdl_mode = MODE_DONE;
            r.status = ST_DONE;
          end
        end
        default: r.status = ST_DONE;
      endcase
    end
    if (r.status == ST_DONE) n_done++;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building blocks
  // --------------------------------------------------------------------------
  function automatic void feed(logic [SAMPLE_W-1:0] v, logic rearm);
    sample_feed.push_back(adc_beat_t'{sample: v, rearm: rearm});
  endfunction

  // Mostly short pauses, a few long ones.
  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One frame attempt under the current register values: rearm, a noisy
  // preamble, a Manchester-coded sync word (true, complemented or with one
  // bit broken), then payload until the capture ends. Returns the number of
  // beats that exercise the search and capture logic.
  function automatic int feed_frame(int style);
    logic [SYNC_BITS-1:0] word;
    logic [SAMPLE_W-1:0]  lo, hi, v;
    logic                 flat;
    int counted, n, stop, words, cut;
    counted = 0;
    feed(SAMPLE_W'($urandom), 1'b1);

    n = $urandom_range(0, 24);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else v = SAMPLE_W'($urandom);
      feed(v, 1'b0);
    end
    counted += n;

    word = mdl_pattern[SYNC_BITS-1:0];
    if (style == 1) word = ~word;
    if (style == 2) word[$urandom_range(0, SYNC_BITS-1)] ^= 1'b1;

    // slot 0 is the oldest, so bit 0 goes in first
    for (int s = 0; s < SLOTS; s++) begin
      lo   = SAMPLE_W'($urandom_range(0, 16'hFFFE));
      hi   = ($urandom_range(0, 7) == 0) ? lo + 1'b1
             : SAMPLE_W'($urandom_range(int'(lo) + 1, 16'hFFFF));
      // a level slot (zero difference) must also read as 0
      flat = !word[s] && $urandom_range(0, 5) == 0;
      for (int j = 0; j < SLOT_LEN; j++) begin
        if (flat) v = lo;
        else v = ((j < HALF_LEN) == word[s]) ? hi : lo;
        feed(v, 1'b0);
      end
    end
    counted += WINDOW;

    if (style == 2) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) feed(SAMPLE_W'($urandom), 1'b0);
      return counted + n;
    end

    stop  = (mdl_frame_len > DEPTH) ? DEPTH : int'(mdl_frame_len);
    words = (stop > WINDOW) ? stop - WINDOW : 0;
    if (words > 0 && $urandom_range(0, 7) == 0) begin
      // rearm in the middle of the payload
      cut = $urandom_range(0, words - 1);
      for (int i = 0; i < cut; i++) feed(SAMPLE_W'($urandom), 1'b0);
      feed(SAMPLE_W'($urandom), 1'b1);
      return counted + cut;
    end
    for (int i = 0; i < words; i++) feed(SAMPLE_W'($urandom), 1'b0);
    // end-of-frame beat plus a few that land in done
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) feed(SAMPLE_W'($urandom), 1'b0);
    return counted + words;
  endfunction

  // checked at the falling edge, once every rising-edge update has settled
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_feed.size() != 0 || in_valid || owed_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SYNC_PATTERN) mdl_pattern = data[PAT_W-1:0];
    else mdl_frame_len = data[LEN_W-1:0];
    n_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents one beat at a time from sample_feed. The model is
  // stepped at the edge where a beat is taken. Every control signal gets a
  // single nonblocking update per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : feed_driver
    adc_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_results.push_back(capture_predict(adc_beat_t'{sample: in_sample,
                                                           rearm: in_rearm}));
        beats_fed++;
        // now and then (and once for sure) let the block drain completely
        if ($urandom_range(0, 299) == 0 || beats_fed == 300) hold_for_drain = 1'b1;
      end
      if (in_valid && in_stall) begin
        // stalled beat holds as is
      end else if (hold_for_drain) begin
        in_valid <= 1'b0;
        if (owed_results.size() == 0) hold_for_drain = 1'b0;
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (sample_feed.size() != 0) begin
        nxt = sample_feed.pop_front();
        in_sample <= nxt.sample;
        in_rearm  <= nxt.rearm;
        in_valid  <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_gap = pick_pause();
          if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(40, 150);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each taken result beat and applies random backpressure.
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    cap_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with nothing expected, expected none, got %0d/%0d/%0d",
                   $time, out_status, out_word_index, out_word_value);
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("word_index", want.word_index, out_word_index);
          check_field("word_value", want.word_value, out_word_value);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (stall_calm > 0) begin
        out_stall <= 1'b0;
        stall_calm--;
      end else begin
        stall_left = pick_pause();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
        if ($urandom_range(0, 99) == 0) stall_calm = $urandom_range(40, 150);
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no beat moved for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, owed_results.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int random_beats;
    int roll;
    int style;
    logic [LEN_W-1:0] len;
    random_beats = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Pattern zero, frame length zero. The cleared window already matches,
    // so the first sample syncs and the next one ends the frame at once.
    write_reg(CFG_SYNC_PATTERN, 24'h000000);
    write_reg(CFG_FRAME_LENGTH, 24'h000000);
    feed(16'h0000, 1'b0);   // sync on an all-zero window
    feed(16'hFFFF, 1'b0);   // short frame: ends on first beat
    feed(16'h1234, 1'b0);   // done holds
    feed(16'hFFFF, 1'b1);   // rearm from done
    feed(16'h0000, 1'b1);   // rearm while searching
    feed(16'hFFFF, 1'b0);   // late-heavy slot still reads 0, syncs again
    feed(16'h8000, 1'b0);
    feed(16'h7FFF, 1'b1);
    wait_idle();

    // All-ones pattern: only its complement (all zeros) can match.
    write_reg(CFG_SYNC_PATTERN, 24'hFFFFFF);
    write_reg(CFG_FRAME_LENGTH, 24'd193);
    feed(16'h0000, 1'b0);   // sync on the complement
    feed(16'hFFFF, 1'b0);   // one stored word at index 192
    feed(16'h5A5A, 1'b0);   // capture end
    feed(16'hA5A5, 1'b0);
    feed(16'h0001, 1'b1);
    feed(16'hFFFF, 1'b0);
    feed(16'h0000, 1'b0);
    feed(16'hFFFE, 1'b1);   // rearm in the middle of a capture
    wait_idle();

    // Frame length equal to the window: first beat after sync ends it.
    write_reg(CFG_SYNC_PATTERN, 24'h000000);
    write_reg(CFG_FRAME_LENGTH, 24'd192);
    feed(16'h0000, 1'b1);
    feed(16'h0000, 1'b0);
    feed(16'hC3C3, 1'b0);
    wait_idle();

    // Reset sync word with a frame twice the window long.
    write_reg(CFG_SYNC_PATTERN, SYNC_PATTERN_RST);
    write_reg(CFG_FRAME_LENGTH, 24'd384);
    random_beats += feed_frame(0);

    // Random phases: new register values between phases, a few frames each.
    while (random_beats < RANDOM_BEATS) begin
      wait_idle();
      if ($urandom_range(0, 4) != 0) begin
        roll = $urandom_range(0, 9);
        case (roll)
          6:       write_reg(CFG_SYNC_PATTERN, SYNC_PATTERN_RST);
          7:       write_reg(CFG_SYNC_PATTERN, ~SYNC_PATTERN_RST);
          8:       write_reg(CFG_SYNC_PATTERN, 24'h000000);
          9:       write_reg(CFG_SYNC_PATTERN, 24'hFFFFFF);
          default: write_reg(CFG_SYNC_PATTERN, CFG_W'($urandom));
        endcase
      end
      if ($urandom_range(0, 4) != 0) begin
        roll = $urandom_range(0, 19);
        if (roll < 14) len = LEN_W'($urandom_range(193, 260));
        else if (roll < 16) len = LEN_W'($urandom_range(0, 191));
        else if (roll == 16) len = 13'd192;
        else if (roll == 17) len = 13'd193;
        else len = LEN_W'($urandom_range(261, 500));
        // upper data bits are outside the register and must not matter
        write_reg(CFG_FRAME_LENGTH, {11'($urandom), len});
      end
      repeat ($urandom_range(1, 3)) begin
        roll  = $urandom_range(0, 19);
        style = (roll < 14) ? 0 : (roll < 17) ? 1 : 2;
        random_beats += feed_frame(style);
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);

    $display("Covered %0d beats and %0d register writes: %0d syncs, %0d stored words,",
             beats_fed, n_writes, n_syncs, n_words);
    $display("%0d frame-done beats and %0d rearms, with random gaps and stalls.",
             n_done, n_rearms);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
